FILE: hdl/rra_pkg.sv
// Shared types, constants and helpers of the rounded rectangle raster engine.
`timescale 1ns / 1ps

package rra_pkg;

    localparam int CFG_W      = 9;
    localparam int CFG_MAX    = (2 ** CFG_W) - 1;
    localparam int CFG_IDX_W  = 2;
    localparam int FIELD_W    = 12;
    localparam int RAD_W      = 11;
    localparam int COLOUR_W   = 32;
    localparam int CHAN_W     = 8;
    localparam int COORD_W    = 15;
    localparam int MUL_W      = 11;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int SUM_W      = 2 * CHAN_W;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

    // Command codes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_FILL  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    // Colour channel selects, red first
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [FIELD_W-1:0] rect_x;
        logic signed [FIELD_W-1:0] rect_y;
        logic [FIELD_W-1:0]        rect_w;
        logic [FIELD_W-1:0]        rect_h;
        logic [COLOUR_W-1:0]       fill_colour;
        logic [RAD_W-1:0]          radius_top_left;
        logic [RAD_W-1:0]          radius_top_right;
        logic [RAD_W-1:0]          radius_bottom_left;
        logic [RAD_W-1:0]          radius_bottom_right;
    } t_cmd;

    typedef struct packed {
        logic [COLOUR_W-1:0] pixel_value;
        logic                pixel_valid;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SETUP,
        S_CLR,
        S_BASE,
        S_PIX,
        S_ARC0,
        S_ARC1,
        S_ARC2,
        S_ARC3,
        S_PLOT,
        S_BL_F,
        S_BL_B,
        S_BL_W,
        S_NEXT,
        S_RD_ADDR,
        S_RD_WAIT,
        S_RD_DATA,
        S_RESP
    } t_state;

    function automatic t_coord sext_field(input logic [FIELD_W-1:0] v);
        sext_field = $signed({{(COORD_W-FIELD_W){v[FIELD_W-1]}}, v});
    endfunction

    function automatic t_coord zext_field(input logic [FIELD_W-1:0] v);
        zext_field = $signed({{(COORD_W-FIELD_W){1'b0}}, v});
    endfunction

    function automatic t_coord zext_rad(input logic [RAD_W-1:0] v);
        zext_rad = $signed({{(COORD_W-RAD_W){1'b0}}, v});
    endfunction

    function automatic t_coord zext_cfg(input logic [CFG_W-1:0] v);
        zext_cfg = $signed({{(COORD_W-CFG_W){1'b0}}, v});
    endfunction

endpackage

FILE: hdl/rra_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module rra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/rounded_rect_alpha_raster.sv
// Top level of the rounded rectangle raster engine: sequencer, shared multiplier, pixel store.
`timescale 1ns / 1ps

// The engine owns a store of MAX_WIDTH*MAX_HEIGHT ARGB words, addressed row-major
// with the saturated screen width as stride, and runs one command at a time:
// clear, fill a rounded rectangle, or read one pixel. Every command returns one
// result item; only an on-screen read returns a pixel and a set valid flag.
// A clear sweeps the visible area with one store write per cycle. An on-screen read
// forms its address with the row-base multiply and then reads the store through its
// registered read port; an off-screen read and an unused command go straight to the
// result, as does a fill whose clipped box is empty. Any other fill forms the row base,
// then for each pixel of the clipped box picks the corner square to test; inside one,
// the arc test squares the two distances and the radius and skips the pixel beyond the
// arc. A drawn pixel is written directly, left alone for alpha 0, or blended (alpha
// other than 0 or 255) from a front and a back term per channel. All multiplies (screen
// area, row base, arc distances and blend terms) go through one 11 by 11 multiplier in
// turn. The command port is ready only while the engine is idle; it takes a new
// command while a finished result still waits on the output register. Configuration
// writes are always taken and should be issued only when no command is in flight. The
// store has no reset: read only pixels that a clear or fill has written.
module rounded_rect_alpha_raster
    import rra_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  t_cmd                 i_cmd,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_res                 o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int W_CAP = (MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH;
    localparam int H_CAP = (MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT;

    // Control registers
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cfg_w, n_cfg_w;
    logic [CFG_W-1:0]   r_cfg_h, n_cfg_h;
    logic               r_res_valid, n_res_valid;

    // Command and working registers
    logic [1:0]          r_mode, n_mode;
    logic [COLOUR_W-1:0] r_colour, n_colour;
    t_coord              r_c0, n_c0, r_c1, n_c1, r_r1, n_r1;
    t_coord              r_px, n_px, r_py, n_py;
    t_coord              r_tl_x, n_tl_x, r_tl_y, n_tl_y;
    t_coord              r_tr_x, n_tr_x, r_tr_y, n_tr_y;
    t_coord              r_bl_x, n_bl_x, r_bl_y, n_bl_y;
    t_coord              r_br_x, n_br_x, r_br_y, n_br_y;
    logic [RAD_W-1:0]    r_rad_tl, n_rad_tl, r_rad_tr, n_rad_tr;
    logic [RAD_W-1:0]    r_rad_bl, n_rad_bl, r_rad_br, n_rad_br;
    logic                r_hit, n_hit;
    logic                r_empty, n_empty;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [RAD_W-1:0]    r_dx, n_dx, r_dy, n_dy, r_rad, n_rad;
    logic [AW-1:0]       r_addr, n_addr, r_row_base, n_row_base;
    logic [1:0]          r_ch, n_ch;
    logic [SUM_W-1:0]    r_mix, n_mix;
    logic [COLOUR_W-1:0] r_pix, n_pix;
    logic                r_pix_valid, n_pix_valid;
    t_res                r_res, n_res;

    // Shared multiplier
    logic                mul_en;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   w_prod;

    // Store port
    logic                ram_we;
    logic [COLOUR_W-1:0] ram_wdata;
    logic [COLOUR_W-1:0] ram_rdata;

    // Effective screen size and command decode
    logic [CFG_W-1:0]    w_eff_w, w_eff_h;
    t_coord              w_sw, w_sh;
    t_coord              w_x, w_y, w_x_end, w_y_end;
    t_coord              w_c0, w_c1, w_r0, w_r1;
    logic                w_cmd_take;

    // Corner test and blend helpers
    logic                w_in_tl, w_in_tr, w_in_bl, w_in_br;
    logic [CHAN_W-1:0]   w_alpha, w_ialpha, w_front, w_back;
    logic [SUM_W-1:0]    w_sum;
    logic                w_last_col, w_last_row;
    logic                w_clr_last;

    rra_ram #(
        .WIDTH(COLOUR_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_addr),
        .i_wdata(ram_wdata),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    // Saturate the programmed size into the store's bounds
    assign w_eff_w = (r_cfg_w == '0) ? CFG_W'(1) :
                     ((r_cfg_w > CFG_W'(W_CAP)) ? CFG_W'(W_CAP) : r_cfg_w);
    assign w_eff_h = (r_cfg_h == '0) ? CFG_W'(1) :
                     ((r_cfg_h > CFG_W'(H_CAP)) ? CFG_W'(H_CAP) : r_cfg_h);
    assign w_sw    = zext_cfg(w_eff_w);
    assign w_sh    = zext_cfg(w_eff_h);

    // Clip box of the incoming command
    assign w_x     = sext_field(i_cmd.rect_x);
    assign w_y     = sext_field(i_cmd.rect_y);
    assign w_x_end = w_x + zext_field(i_cmd.rect_w);
    assign w_y_end = w_y + zext_field(i_cmd.rect_h);
    assign w_c0    = (w_x < 0) ? '0 : w_x;
    assign w_r0    = (w_y < 0) ? '0 : w_y;
    assign w_c1    = (w_x_end > w_sw) ? w_sw : w_x_end;
    assign w_r1    = (w_y_end > w_sh) ? w_sh : w_y_end;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_cmd_take  = i_cmd_valid && o_cmd_ready;
    assign o_cfg_ready = 1'b1;

    // Corner squares; the first match in order top left, top right, bottom left,
    // bottom right decides
    assign w_in_tl = (r_px < r_tl_x) && (r_py < r_tl_y);
    assign w_in_tr = (r_px >= r_tr_x) && (r_py < r_tr_y);
    assign w_in_bl = (r_px < r_bl_x) && (r_py >= r_bl_y);
    assign w_in_br = (r_px >= r_br_x) && (r_py >= r_br_y);

    assign w_alpha  = r_colour[31:24];
    assign w_ialpha = ALPHA_OPAQUE - w_alpha;
    assign w_sum    = r_acc[SUM_W-1:0] + r_prod[SUM_W-1:0];

    always_comb begin
        unique case (r_ch)
            CH_RED: begin
                w_front = r_colour[23:16];
                w_back  = ram_rdata[23:16];
            end
            CH_GREEN: begin
                w_front = r_colour[15:8];
                w_back  = ram_rdata[15:8];
            end
            default: begin
                w_front = r_colour[7:0];
                w_back  = ram_rdata[7:0];
            end
        endcase
    end

    assign w_last_col = (r_px == (r_c1 - t_coord'(1)));
    assign w_last_row = (r_py == (r_r1 - t_coord'(1)));
    assign w_clr_last = ({1'b0, r_addr} == ((AW+1)'(r_prod) - (AW+1)'(1)));

    assign w_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        n_state     = r_state;
        n_cfg_w     = r_cfg_w;
        n_cfg_h     = r_cfg_h;
        n_res_valid = r_res_valid;
        n_mode      = r_mode;
        n_colour    = r_colour;
        n_c0        = r_c0;
        n_c1        = r_c1;
        n_r1        = r_r1;
        n_px        = r_px;
        n_py        = r_py;
        n_tl_x      = r_tl_x;
        n_tl_y      = r_tl_y;
        n_tr_x      = r_tr_x;
        n_tr_y      = r_tr_y;
        n_bl_x      = r_bl_x;
        n_bl_y      = r_bl_y;
        n_br_x      = r_br_x;
        n_br_y      = r_br_y;
        n_rad_tl    = r_rad_tl;
        n_rad_tr    = r_rad_tr;
        n_rad_bl    = r_rad_bl;
        n_rad_br    = r_rad_br;
        n_hit       = r_hit;
        n_empty     = r_empty;
        n_acc       = r_acc;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_rad       = r_rad;
        n_addr      = r_addr;
        n_row_base  = r_row_base;
        n_ch        = r_ch;
        n_mix       = r_mix;
        n_pix       = r_pix;
        n_pix_valid = r_pix_valid;
        n_res       = r_res;
        mul_en      = 1'b0;
        mul_a       = MUL_W'(w_eff_w);
        mul_b       = MUL_W'(w_eff_h);
        ram_we      = 1'b0;
        ram_wdata   = r_colour;

        // Drop the result once the consumer takes it
        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  n_cfg_w = i_cfg_data;
                CFG_SCREEN_HEIGHT: n_cfg_h = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_cmd_take) begin
                    n_mode      = i_cmd.mode;
                    n_colour    = i_cmd.fill_colour;
                    n_c0        = w_c0;
                    n_c1        = w_c1;
                    n_r1        = w_r1;
                    n_px        = (i_cmd.mode == MODE_FILL) ? w_c0 : w_x;
                    n_py        = (i_cmd.mode == MODE_FILL) ? w_r0 : w_y;
                    n_rad_tl    = i_cmd.radius_top_left;
                    n_rad_tr    = i_cmd.radius_top_right;
                    n_rad_bl    = i_cmd.radius_bottom_left;
                    n_rad_br    = i_cmd.radius_bottom_right;
                    n_tl_x      = w_x + zext_rad(i_cmd.radius_top_left);
                    n_tl_y      = w_y + zext_rad(i_cmd.radius_top_left);
                    n_tr_x      = w_x_end - zext_rad(i_cmd.radius_top_right);
                    n_tr_y      = w_y + zext_rad(i_cmd.radius_top_right);
                    n_bl_x      = w_x + zext_rad(i_cmd.radius_bottom_left);
                    n_bl_y      = w_y_end - zext_rad(i_cmd.radius_bottom_left);
                    n_br_x      = w_x_end - zext_rad(i_cmd.radius_bottom_right);
                    n_br_y      = w_y_end - zext_rad(i_cmd.radius_bottom_right);
                    n_hit       = (w_x >= 0) && (w_x < w_sw) && (w_y >= 0) && (w_y < w_sh);
                    n_empty     = (w_c1 <= w_c0) || (w_r1 <= w_r0);
                    n_pix       = '0;
                    n_pix_valid = 1'b0;
                    n_state     = S_SETUP;
                end
            end

            // One multiply: screen area for a clear, row base for fill or read
            S_SETUP: begin
                mul_en = 1'b1;
                if (r_mode != MODE_CLEAR) begin
                    mul_a = MUL_W'($unsigned(r_py));
                    mul_b = MUL_W'(w_eff_w);
                end
                n_addr = '0;
                unique case (r_mode)
                    MODE_CLEAR: n_state = S_CLR;
                    MODE_FILL:  n_state = r_empty ? S_RESP : S_BASE;
                    MODE_READ:  n_state = r_hit ? S_RD_ADDR : S_RESP;
                    default:    n_state = S_RESP;
                endcase
            end

            // Sweep the visible area unblended, one word a cycle
            S_CLR: begin
                ram_we = 1'b1;
                n_addr = r_addr + AW'(1);
                if (w_clr_last) begin
                    n_state = S_RESP;
                end
            end

            S_BASE: begin
                n_row_base = AW'(r_prod);
                n_state    = S_PIX;
            end

            // Pick the corner to test and form the pixel address
            S_PIX: begin
                n_addr = r_row_base + AW'($unsigned(r_px));
                priority if (w_in_tl) begin
                    n_dx    = RAD_W'(r_tl_x - r_px);
                    n_dy    = RAD_W'(r_tl_y - r_py);
                    n_rad   = r_rad_tl;
                    n_state = S_ARC0;
                end else if (w_in_tr) begin
                    n_dx    = RAD_W'(r_px - r_tr_x + t_coord'(1));
                    n_dy    = RAD_W'(r_tr_y - r_py);
                    n_rad   = r_rad_tr;
                    n_state = S_ARC0;
                end else if (w_in_bl) begin
                    n_dx    = RAD_W'(r_bl_x - r_px);
                    n_dy    = RAD_W'(r_py - r_bl_y + t_coord'(1));
                    n_rad   = r_rad_bl;
                    n_state = S_ARC0;
                end else if (w_in_br) begin
                    n_dx    = RAD_W'(r_px - r_br_x + t_coord'(1));
                    n_dy    = RAD_W'(r_py - r_br_y + t_coord'(1));
                    n_rad   = r_rad_br;
                    n_state = S_ARC0;
                end else begin
                    n_state = S_PLOT;
                end
            end

            S_ARC0: begin
                mul_en  = 1'b1;
                mul_a   = r_dx;
                mul_b   = r_dx;
                n_state = S_ARC1;
            end

            S_ARC1: begin
                mul_en  = 1'b1;
                mul_a   = r_dy;
                mul_b   = r_dy;
                n_acc   = ACC_W'(r_prod);
                n_state = S_ARC2;
            end

            S_ARC2: begin
                mul_en  = 1'b1;
                mul_a   = r_rad;
                mul_b   = r_rad;
                n_acc   = r_acc + ACC_W'(r_prod);
                n_state = S_ARC3;
            end

            // Skip the pixel when it lies beyond the arc
            S_ARC3: begin
                n_state = (r_acc <= ACC_W'(r_prod)) ? S_PLOT : S_NEXT;
            end

            // The store read issued here feeds the blend states
            S_PLOT: begin
                n_ch = CH_RED;
                priority if (w_alpha == ALPHA_OPAQUE) begin
                    ram_we  = 1'b1;
                    n_state = S_NEXT;
                end else if (w_alpha == ALPHA_CLEAR) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_BL_F;
                end
            end

            // Front term of this channel; bank the previous channel's result
            S_BL_F: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(w_front);
                mul_b  = MUL_W'(w_alpha);
                if (r_ch != CH_RED) begin
                    n_mix = {r_mix[CHAN_W-1:0], w_sum[SUM_W-1:CHAN_W]};
                end
                n_state = S_BL_B;
            end

            // Back term of this channel
            S_BL_B: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(w_back);
                mul_b  = MUL_W'(w_ialpha);
                n_acc  = ACC_W'(r_prod);
                if (r_ch == CH_BLUE) begin
                    n_state = S_BL_W;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = S_BL_F;
                end
            end

            S_BL_W: begin
                ram_we    = 1'b1;
                ram_wdata = {ALPHA_OPAQUE, r_mix, w_sum[SUM_W-1:CHAN_W]};
                n_state   = S_NEXT;
            end

            // Advance along the row, then down to the next row
            S_NEXT: begin
                if (w_last_col) begin
                    if (w_last_row) begin
                        n_state = S_RESP;
                    end else begin
                        n_px       = r_c0;
                        n_py       = r_py + t_coord'(1);
                        n_row_base = r_row_base + AW'(w_eff_w);
                        n_state    = S_PIX;
                    end
                end else begin
                    n_px    = r_px + t_coord'(1);
                    n_state = S_PIX;
                end
            end

            S_RD_ADDR: begin
                n_addr  = AW'(r_prod) + AW'($unsigned(r_px));
                n_state = S_RD_WAIT;
            end

            S_RD_WAIT: begin
                n_state = S_RD_DATA;
            end

            S_RD_DATA: begin
                n_pix       = ram_rdata;
                n_pix_valid = 1'b1;
                n_state     = S_RESP;
            end

            // Hold the result until the output register is free
            S_RESP: begin
                if (!r_res_valid || i_res_ready) begin
                    n_res.pixel_value = r_pix;
                    n_res.pixel_valid = r_pix_valid;
                    n_res_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_w     <= CFG_RESET;
            r_cfg_h     <= CFG_RESET;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg_w     <= n_cfg_w;
            r_cfg_h     <= n_cfg_h;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_colour    <= n_colour;
        r_c0        <= n_c0;
        r_c1        <= n_c1;
        r_r1        <= n_r1;
        r_px        <= n_px;
        r_py        <= n_py;
        r_tl_x      <= n_tl_x;
        r_tl_y      <= n_tl_y;
        r_tr_x      <= n_tr_x;
        r_tr_y      <= n_tr_y;
        r_bl_x      <= n_bl_x;
        r_bl_y      <= n_bl_y;
        r_br_x      <= n_br_x;
        r_br_y      <= n_br_y;
        r_rad_tl    <= n_rad_tl;
        r_rad_tr    <= n_rad_tr;
        r_rad_bl    <= n_rad_bl;
        r_rad_br    <= n_rad_br;
        r_hit       <= n_hit;
        r_empty     <= n_empty;
        r_acc       <= n_acc;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_rad       <= n_rad;
        r_addr      <= n_addr;
        r_row_base  <= n_row_base;
        r_ch        <= n_ch;
        r_mix       <= n_mix;
        r_pix       <= n_pix;
        r_pix_valid <= n_pix_valid;
        r_res       <= n_res;
        if (mul_en) begin
            r_prod <= w_prod;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the rounded rectangle raster engine: directed and random commands.
`timescale 1ns / 1ps

module tb_top;
    import rra_pkg::*;

    // Codes the package leaves unnamed: the spare command and the spare register slots.
    localparam logic [1:0]           MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Watchdog limit on the run of cycles with no handshake at all.
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int LONG_HOLD      = 8000;
    localparam int SETTLE_CYCLES  = 16;

    // Keeps its own copy of the pixel store and the screen registers and works out the
    // answer of every accepted command, then matches the answers as they come back.
    class raster_scoreboard;
        bit [COLOUR_W-1:0] pixels [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
        bit [CFG_W-1:0]    width_reg  = CFG_RESET;
        bit [CFG_W-1:0]    height_reg = CFG_RESET;
        t_res              due [$];
        int                mismatches;
        int                checked;
        int                hits;

        // Saturate a register into the range the store can hold.
        function int span(input bit [CFG_W-1:0] v, input int top);
            if (v == 0) return 1;
            if (int'(v) > top) return top;
            return int'(v);
        endfunction

        function int screen_w();
            return span(width_reg, DEF_MAX_WIDTH);
        endfunction

        function int screen_h();
            return span(height_reg, DEF_MAX_HEIGHT);
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
            if (idx == CFG_SCREEN_WIDTH) width_reg = val;
            else if (idx == CFG_SCREEN_HEIGHT) height_reg = val;
        endfunction

        function bit [COLOUR_W-1:0] mix_over(input bit [COLOUR_W-1:0] front,
                                             input bit [COLOUR_W-1:0] back);
            int a;
            int ia;
            bit [COLOUR_W-1:0] mixed;
            a  = int'(front[31:24]);
            ia = 255 - a;
            mixed[31:24] = ALPHA_OPAQUE;
            mixed[23:16] = CHAN_W'((int'(front[23:16]) * a + int'(back[23:16]) * ia) >> 8);
            mixed[15:8]  = CHAN_W'((int'(front[15:8]) * a + int'(back[15:8]) * ia) >> 8);
            mixed[7:0]   = CHAN_W'((int'(front[7:0]) * a + int'(back[7:0]) * ia) >> 8);
            return mixed;
        endfunction

        function void plot_dot(input int px, input int py, input bit [COLOUR_W-1:0] colour);
            int sw;
            int sh;
            int idx;
            sw = screen_w();
            sh = screen_h();
            if (px < 0 || px >= sw || py < 0 || py >= sh) return;
            idx = py * sw + px;
            if (colour[31:24] == ALPHA_OPAQUE) pixels[idx] = colour;
            else if (colour[31:24] != ALPHA_CLEAR) pixels[idx] = mix_over(colour, pixels[idx]);
        endfunction

        function bit on_arc(input int dx, input int dy, input int r);
            return dx * dx + dy * dy <= r * r;
        endfunction

        // Walk the clipped box; only the first corner square holding the pixel is tested.
        function void fill_shape(input int x, input int y, input int w, input int h,
                                 input bit [COLOUR_W-1:0] colour,
                                 input int tl, input int tr, input int bl, input int br);
            int c0;
            int c1;
            int r0;
            int r1;
            int px;
            int py;
            bit paint;
            c0 = (x < 0) ? 0 : x;
            c1 = (x + w > screen_w()) ? screen_w() : x + w;
            r0 = (y < 0) ? 0 : y;
            r1 = (y + h > screen_h()) ? screen_h() : y + h;
            for (py = r0; py < r1; py++) begin
                for (px = c0; px < c1; px++) begin
                    paint = 1'b1;
                    if (px < x + tl && py < y + tl)
                        paint = on_arc(x + tl - px, y + tl - py, tl);
                    else if (px >= x + w - tr && py < y + tr)
                        paint = on_arc(px - (x + w - tr - 1), y + tr - py, tr);
                    else if (px < x + bl && py >= y + h - bl)
                        paint = on_arc(x + bl - px, py - (y + h - bl - 1), bl);
                    else if (px >= x + w - br && py >= y + h - br)
                        paint = on_arc(px - (x + w - br - 1), py - (y + h - br - 1), br);
                    if (paint) plot_dot(px, py, colour);
                end
            end
        endfunction

        function void note_command(input t_cmd c);
            t_res want;
            int x;
            int y;
            int sw;
            int sh;
            int i;
            x  = {{(32-FIELD_W){c.rect_x[FIELD_W-1]}}, c.rect_x};
            y  = {{(32-FIELD_W){c.rect_y[FIELD_W-1]}}, c.rect_y};
            sw = screen_w();
            sh = screen_h();
            want = '0;
            case (c.mode)
                MODE_CLEAR: begin
                    for (i = 0; i < sw * sh; i++) pixels[i] = c.fill_colour;
                end
                MODE_FILL: begin
                    fill_shape(x, y, int'(c.rect_w), int'(c.rect_h), c.fill_colour,
                               int'(c.radius_top_left), int'(c.radius_top_right),
                               int'(c.radius_bottom_left), int'(c.radius_bottom_right));
                end
                MODE_READ: begin
                    if (x >= 0 && x < sw && y >= 0 && y < sh) begin
                        want.pixel_value = pixels[y * sw + x];
                        want.pixel_valid = 1'b1;
                    end
                end
                default: ;
            endcase
            due.push_back(want);
        endfunction

        task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
            $display("mismatch on %s at result %0d: got %h, expected %h", what, checked, got, want);
            mismatches++;
        endtask

        task check_result(input t_res r);
            t_res want;
            checked++;
            if (due.size() == 0) begin
                report_mismatch("result with nothing pending", r.pixel_value, '0);
                return;
            end
            want = due.pop_front();
            if (want.pixel_valid) hits++;
            if (r.pixel_value !== want.pixel_value)
                report_mismatch("pixel_value", r.pixel_value, want.pixel_value);
            if (r.pixel_valid !== want.pixel_valid)
                report_mismatch("pixel_valid", r.pixel_valid, want.pixel_valid);
        endtask
    endclass

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cmd_valid  = 1'b0;
    t_cmd                 cmd_bus    = '0;
    logic                 res_ready  = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_SCREEN_WIDTH;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 cmd_ready;
    logic                 res_valid;
    logic                 cfg_ready;
    t_res                 res_bus;

    raster_scoreboard sb = new;

    bit quiet_tail   = 1'b0;  // no idling on either side once set
    bit hold_request = 1'b0;  // ask the receiver for one long hold-off
    int stall_count  = 0;
    int cfg_writes   = 0;
    int kind_count [4] = '{default: 0};

    rounded_rect_alpha_raster uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd_bus),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res_bus),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Observe every handshake at the edge that completes it: predict on an accepted
    // command, check on an accepted result, track register writes, count dead cycles.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_valid && cmd_ready) begin
                sb.note_command(cmd_bus);
                kind_count[cmd_bus.mode]++;
            end
            if (res_valid && res_ready) sb.check_result(res_bus);
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
        end
    end

    // End the run if nothing moves for too long; a lost result lands here too.
    initial begin
        while (stall_count < WATCHDOG_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // Result side: take results, stall in short random bursts, and hold off once for a
    // long stretch so that the engine backs up and drops its command ready.
    initial begin
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                res_ready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                res_ready <= 1'b1;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    function automatic t_cmd make_cmd(input logic [1:0] m, input int x, input int y,
                                      input int w, input int h, input logic [31:0] colour,
                                      input int tl, input int tr, input int bl, input int br);
        t_cmd c;
        c.mode                = m;
        c.rect_x              = x[FIELD_W-1:0];
        c.rect_y              = y[FIELD_W-1:0];
        c.rect_w              = w[FIELD_W-1:0];
        c.rect_h              = h[FIELD_W-1:0];
        c.fill_colour         = colour;
        c.radius_top_left     = tl[RAD_W-1:0];
        c.radius_top_right    = tr[RAD_W-1:0];
        c.radius_bottom_left  = bl[RAD_W-1:0];
        c.radius_bottom_right = br[RAD_W-1:0];
        return c;
    endfunction

    function automatic int corner_radius(input int rmax);
        return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, rmax));
    endfunction

    // Offer one command and hold it until taken; sometimes idle afterwards.
    task automatic issue(input t_cmd c);
        cmd_bus   <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic read_at(input int x, input int y);
        issue(make_cmd(MODE_READ, x, y, 0, 0, '0, 0, 0, 0, 0));
    endtask

    // Drop valid and wait for every outstanding answer.
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.due.size() != 0) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram the screen while idle, then clear it so every on-screen read hits a
    // written word.
    task automatic start_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        write_cfg(CFG_SCREEN_WIDTH, w);
        write_cfg(CFG_SCREEN_HEIGHT, h);
        issue(make_cmd(MODE_CLEAR, 0, 0, 0, 0, $urandom, 0, 0, 0, 0));
    endtask

    // Random commands; wide opens up the full field ranges, which only small screens
    // can afford since the fill cost follows the clipped box.
    task automatic random_batch(input int count, input bit wide);
        t_cmd c;
        int n;
        int sw;
        int sh;
        int pick;
        int x;
        int y;
        int w;
        int h;
        int wmax;
        int hmax;
        int rmax;
        logic [31:0] colour;
        for (n = 0; n < count; n++) begin
            sw     = sb.screen_w();
            sh     = sb.screen_h();
            pick   = $urandom_range(0, 99);
            colour = $urandom;
            case ($urandom_range(0, 3))
                0:       colour[31:24] = ALPHA_CLEAR;
                1:       colour[31:24] = ALPHA_OPAQUE;
                default: ;
            endcase
            if (pick < 40) begin
                if (wide && $urandom_range(0, 1) == 1) begin
                    x = int'($urandom_range(0, 4095)) - 2048;
                    y = int'($urandom_range(0, 4095)) - 2048;
                    w = $urandom_range(0, 2048);
                    h = $urandom_range(0, 2048);
                    c = make_cmd(MODE_FILL, x, y, w, h, colour,
                                 $urandom_range(0, 1024), $urandom_range(0, 1024),
                                 $urandom_range(0, 1024), $urandom_range(0, 1024));
                end else begin
                    wmax = (sw + 8 > 32) ? 32 : sw + 8;
                    hmax = (sh + 8 > 32) ? 32 : sh + 8;
                    x    = int'($urandom_range(0, sw + 8)) - 4;
                    y    = int'($urandom_range(0, sh + 8)) - 4;
                    w    = $urandom_range(0, wmax);
                    h    = $urandom_range(0, hmax);
                    rmax = ((w > h) ? w : h) / 2 + 1;
                    c = make_cmd(MODE_FILL, x, y, w, h, colour,
                                 corner_radius(rmax), corner_radius(rmax),
                                 corner_radius(rmax), corner_radius(rmax));
                end
            end else if (pick < 75) begin
                c = make_cmd(MODE_READ, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                             0, 0, '0, 0, 0, 0, 0);
            end else if (pick < 85 && sw * sh <= 4096) begin
                c = make_cmd(MODE_CLEAR, 0, 0, 0, 0, colour, 0, 0, 0, 0);
            end else if (pick < 92) begin
                c = make_cmd(MODE_UNUSED, int'($urandom_range(0, 4095)) - 2048,
                             int'($urandom_range(0, 4095)) - 2048,
                             $urandom_range(0, 2048), $urandom_range(0, 2048), colour,
                             $urandom_range(0, 1024), $urandom_range(0, 1024),
                             $urandom_range(0, 1024), $urandom_range(0, 1024));
            end else begin
                // mostly off the screen, so the valid flag must stay low
                c = make_cmd(MODE_READ, int'($urandom_range(0, 4095)) - 2048,
                             int'($urandom_range(0, 4095)) - 2048, 0, 0, '0, 0, 0, 0, 0);
            end
            issue(c);
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset screen of 256 by 256. Nothing on screen is read
        // before the first clear, as the store comes up unwritten.
        issue(make_cmd(MODE_UNUSED, 5, 5, 3, 3, 32'hFFFF_FFFF, 1, 1, 1, 1));
        read_at(-1, 0);
        issue(make_cmd(MODE_CLEAR, 0, 0, 0, 0, 32'hFF10_2030, 0, 0, 0, 0));
        read_at(0, 0);
        read_at(255, 255);
        read_at(256, 0);
        read_at(0, 256);
        read_at(2047, -2048);
        // plain rectangle, then a blended one with a different radius per corner
        issue(make_cmd(MODE_FILL, 2, 3, 10, 6, 32'hFFAA_5500, 0, 0, 0, 0));
        read_at(11, 8);
        issue(make_cmd(MODE_FILL, 20, 20, 12, 10, 32'h80C0_4010, 4, 3, 2, 5));
        read_at(20, 20);
        read_at(24, 24);
        // alpha zero leaves the store alone
        issue(make_cmd(MODE_FILL, 20, 20, 4, 4, 32'h00FF_FFFF, 0, 0, 0, 0));
        // overlapping corner squares: the first corner in order wins
        issue(make_cmd(MODE_FILL, 40, 40, 6, 6, 32'h7F00_FF00, 5, 5, 5, 5));
        // clip on the top left and on the bottom right
        issue(make_cmd(MODE_FILL, -5, -4, 12, 10, 32'hC012_3456, 6, 1, 2, 3));
        issue(make_cmd(MODE_FILL, 250, 251, 20, 20, 32'hFF00_FFFF, 3, 0, 0, 1024));
        // field extremes, fully clipped, then a one-pixel row clipped at the left edge
        issue(make_cmd(MODE_FILL, 2047, 2047, 2048, 2048, 32'hFFFF_FFFF, 1024, 1024, 1024, 1024));
        issue(make_cmd(MODE_FILL, -2048, -2048, 2048, 2048, 32'h0000_0000, 1024, 1024, 1024, 1024));
        issue(make_cmd(MODE_FILL, -1800, 100, 2048, 1, 32'hFFFF_FFFF, 0, 0, 0, 0));
        read_at(0, 0);
        read_at(252, 253);
        read_at(247, 100);
        read_at(248, 100);

        // Random part over a run of screen settings, the extremes among them.
        start_phase(9'd8, 9'd8);
        random_batch(16, 1'b1);
        start_phase(9'd0, 9'd1);        // width saturates up to one column
        random_batch(8, 1'b1);
        start_phase(9'd511, 9'd2);      // width saturates down to the store width
        random_batch(7, 1'b1);
        wait_idle();                    // sender pause with everything answered
        random_batch(7, 1'b1);
        start_phase(9'd3, 9'd256);
        random_batch(14, 1'b1);
        start_phase(9'd20, 9'd13);
        random_batch(6, 1'b0);
        hold_request = 1'b1;            // back the engine up behind a stalled receiver
        random_batch(18, 1'b0);

        // Final stretch at full size with no idling; writes to the spare slots must be
        // ignored.
        wait_idle();
        quiet_tail = 1'b1;
        write_cfg(CFG_SPARE_LO, 9'h1FF);
        write_cfg(CFG_SPARE_HI, 9'h0AA);
        start_phase(9'd256, 9'd256);
        random_batch(14, 1'b0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d clears, %0d fills, %0d reads and %0d spare commands",
                 kind_count[MODE_CLEAR], kind_count[MODE_FILL], kind_count[MODE_READ],
                 kind_count[MODE_UNUSED]);
        $display("over %0d register writes; %0d answers checked, %0d on-screen reads",
                 cfg_writes, sb.checked, sb.hits);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
